// File: rtl/pwb_pkg.sv
`default_nettype none
package pwb_pkg;

  // Sequencer states, one-hot
  typedef enum logic [14:0] {
    ST_IDLE = 15'h0001,
    ST_FMUL = 15'h0002,
    ST_FDIV = 15'h0004,
    ST_AMUL = 15'h0008,
    ST_ADIV = 15'h0010,
    ST_VMUL = 15'h0020,
    ST_VADD = 15'h0040,
    ST_PMUL = 15'h0080,
    ST_PADD = 15'h0100,
    ST_WMUL = 15'h0200,
    ST_WCMP = 15'h0400,
    ST_CDIV = 15'h0800,
    ST_BMUL = 15'h1000,
    ST_BADD = 15'h2000,
    ST_OUT  = 15'h4000
  } pwb_state_e;

  typedef enum logic [2:0] {
    CFG_PPM    = 3'd0,
    CFG_GRAV_X = 3'd1,
    CFG_GRAV_Y = 3'd2,
    CFG_SCR_W  = 3'd3,
    CFG_SCR_H  = 3'd4
  } pwb_cfg_e;

  localparam logic CMD_OBJECT = 1'b0;
  localparam logic CMD_FRAME  = 1'b1;

  // restitution 0.3 in Q0.16
  localparam logic signed [33:0] REST_Q16 = 34'sd19661;

  // signed result of a magnitude quotient, saturated to 32 bits
  function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [31:0] r;
    if (!neg) begin
      r = (mag > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      r = (mag > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_wide(input logic signed [67:0] v);
    logic [31:0] r;
    if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -68'sh0_0000_0000_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // arithmetic shift right by 16, rounding toward zero
  function automatic logic signed [67:0] shr_tz(input logic signed [67:0] v);
    logic signed [67:0] m;
    m = v[67] ? -v : v;
    m = m >>> 16;
    return v[67] ? -m : m;
  endfunction

endpackage
`default_nettype wire

// File: rtl/particle_wall_bounce_integrator.sv
// Channel | Direction | Handshake                | Payload
// in      | request   | in_valid_i / in_stall_o  | command, position, velocity, force, mass, size, dt
// out     | result    | out_valid_o / out_stall_i| new position, new velocity
// cfg     | write     | cfg_valid_i / cfg_ready_o| register index, write data
//
// One shared 34x34 multiplier and one radix-2 divider (64-bit dividend, 32-bit divisor)
// are stepped by a one-hot sequencer; one request is in flight at a time.
// Frame request: a multiply, then one divide per axis; zero dt takes effect in the accept cycle.
// Object request: per axis an acceleration divide and updates, then per wall a check, a divide
// on a hit, a bounce update; an object with no active frame goes straight to the output register.
// The output register holds a result under stall while the next request is accepted.
// Reset (async, active low) restores config defaults, clears frame state, marks no frame.
`default_nettype none
module particle_wall_bounce_integrator
  import pwb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [31:0] x_value_i,
  input  wire logic [31:0] y_value_i,
  input  wire logic [31:0] vel_x_i,
  input  wire logic [31:0] vel_y_i,
  input  wire logic [31:0] force_x_i,
  input  wire logic [31:0] force_y_i,
  input  wire logic [30:0] mass_i,
  input  wire logic [12:0] size_x_i,
  input  wire logic [12:0] size_y_i,
  input  wire logic [15:0] dt_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      new_pos_x_o,
  output logic [31:0]      new_pos_y_o,
  output logic [31:0]      new_vel_x_o,
  output logic [31:0]      new_vel_y_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  pwb_state_e state_q, state_d;
  logic axis_q, axis_d;   // 0 = x, 1 = y
  logic side_q, side_d;   // 0 = low wall, 1 = high wall
  logic dgo_q, dgo_d;     // divider load cycle
  logic skip_q, skip_d;   // no active frame

  // configuration
  logic [15:0] ppm_q;
  logic [31:0] grav_q [2];
  logic [12:0] scr_q  [2];

  // frame state
  logic [15:0] prev_q [2];
  logic [31:0] wall_q [2];
  logic [15:0] fdt_q;

  // request payload and working values
  logic [31:0] pos_q [2];
  logic [31:0] vel_q [2];
  logic [31:0] frc_q [2];
  logic [12:0] siz_q [2];
  logic [30:0] mass_q;
  logic [15:0] dt_q;
  logic [31:0] acc_q;
  logic signed [67:0] prod_q;

  // divider
  logic [31:0] rem_q, dden_q;
  logic [63:0] quo_q;
  logic [6:0]  dcnt_q;
  logic        dneg_q;

  logic out_valid_q;
  logic [31:0] out_px_q, out_py_q, out_vx_q, out_vy_q;

  logic in_acc, out_free, div_st, div_done;
  logic [15:0] ppm_eff;
  logic [31:0] div_res;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign ppm_eff     = (ppm_q == 16'd0) ? 16'd1 : ppm_q;
  assign div_st      = (state_q == ST_FDIV) || (state_q == ST_ADIV) || (state_q == ST_CDIV);
  assign div_done    = div_st && !dgo_q && dcnt_q[6];
  assign div_res     = sat_mag(dneg_q, quo_q);

  // per-axis selections
  logic [31:0] pos_sel, vel_sel, wall_sel, frc_sel;
  logic [15:0] cur_sel;
  logic [12:0] scr_sel, siz_sel;
  assign pos_sel  = pos_q[axis_q];
  assign vel_sel  = vel_q[axis_q];
  assign wall_sel = wall_q[axis_q];
  assign frc_sel  = frc_q[axis_q];
  assign cur_sel  = prev_q[axis_q];
  assign scr_sel  = scr_q[axis_q];
  assign siz_sel  = siz_q[axis_q];

  // wall geometry, pixels
  logic signed [33:0] rel;
  logic signed [17:0] edge_pix, clamp_pix;
  logic signed [67:0] lim_lo, lim_hi, siz_w;
  logic hit, into;
  assign rel       = $signed({{2{vel_sel[31]}}, vel_sel}) - $signed({{2{wall_sel[31]}}, wall_sel});
  assign edge_pix  = $signed({{2{cur_sel[15]}}, cur_sel}) + $signed({5'b0, scr_sel});
  assign clamp_pix = side_q ? (edge_pix - $signed({5'b0, siz_sel}))
                            : $signed({{2{cur_sel[15]}}, cur_sel});
  assign lim_lo    = $signed({{28{cur_sel[15]}}, cur_sel, 24'b0});
  assign lim_hi    = $signed({{26{edge_pix[17]}}, edge_pix, 24'b0});
  assign siz_w     = $signed({31'b0, siz_sel, 24'b0});
  assign hit       = side_q ? ((prod_q + siz_w) > lim_hi) : (prod_q < lim_lo);
  assign into      = side_q ? (rel > 34'sd0) : rel[33];

  // shared multiplier operands
  logic signed [33:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_FMUL: begin
        mul_a = $signed({18'b0, ppm_eff});
        mul_b = $signed({18'b0, dt_q});
      end
      ST_AMUL: begin
        mul_a = $signed({3'b0, mass_q});
        mul_b = $signed({{2{grav_q[axis_q][31]}}, grav_q[axis_q]});
      end
      ST_VMUL: begin
        mul_a = $signed({{2{acc_q[31]}}, acc_q});
        mul_b = $signed({18'b0, fdt_q});
      end
      ST_PMUL: begin
        mul_a = $signed({{2{vel_sel[31]}}, vel_sel});
        mul_b = $signed({18'b0, fdt_q});
      end
      ST_WMUL: begin
        mul_a = $signed({{2{pos_sel[31]}}, pos_sel});
        mul_b = $signed({18'b0, ppm_eff});
      end
      ST_BMUL: begin
        mul_a = -rel;
        mul_b = REST_Q16;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider operands at load
  logic signed [16:0] delta;
  logic signed [63:0] div_num;
  logic [31:0] div_den;
  assign delta = $signed({pos_sel[15], pos_sel[15:0]}) - $signed({cur_sel[15], cur_sel});
  always_comb begin
    div_num = '0;
    div_den = 32'd1;
    case (state_q)
      ST_FDIV: begin
        div_num = $signed({{7{delta[16]}}, delta, 40'b0});
        div_den = prod_q[31:0];
      end
      ST_ADIV: begin
        div_num = $signed({{16{frc_sel[31]}}, frc_sel, 16'b0}) + prod_q[63:0];
        div_den = {1'b0, mass_q};
      end
      ST_CDIV: begin
        div_num = $signed({{22{clamp_pix[17]}}, clamp_pix, 24'b0});
        div_den = {16'b0, ppm_eff};
      end
      default: begin
        div_num = '0;
        div_den = 32'd1;
      end
    endcase
  end

  logic [32:0] cand;
  logic        cand_ge;
  assign cand    = {rem_q, quo_q[63]};
  assign cand_ge = cand >= {1'b0, dden_q};

  // step to the next wall check, or finish
  pwb_state_e nw_state;
  logic nw_axis, nw_side;
  always_comb begin
    nw_state = ST_OUT;
    nw_axis  = axis_q;
    nw_side  = side_q;
    if (!side_q) begin
      nw_side  = 1'b1;
      nw_state = ST_WMUL;
    end else if (!axis_q) begin
      nw_axis  = 1'b1;
      nw_side  = 1'b0;
      nw_state = ST_WMUL;
    end
  end

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    side_d  = side_q;
    dgo_d   = 1'b0;
    skip_d  = skip_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          axis_d = 1'b0;
          side_d = 1'b0;
          if (command_i == CMD_FRAME) begin
            if (dt_i == 16'd0) begin
              skip_d = 1'b1;
            end else begin
              state_d = ST_FMUL;
            end
          end else if (skip_q) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_AMUL;
          end
        end
      end
      ST_FMUL: begin
        state_d = ST_FDIV;
        dgo_d   = 1'b1;
      end
      ST_FDIV: begin
        if (div_done) begin
          if (!axis_q) begin
            axis_d = 1'b1;
            dgo_d  = 1'b1;
          end else begin
            axis_d  = 1'b0;
            skip_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      ST_AMUL: begin
        state_d = ST_ADIV;
        dgo_d   = 1'b1;
      end
      ST_ADIV: begin
        if (div_done) state_d = ST_VMUL;
      end
      ST_VMUL: state_d = ST_VADD;
      ST_VADD: state_d = ST_PMUL;
      ST_PMUL: state_d = ST_PADD;
      ST_PADD: begin
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = ST_AMUL;
        end else begin
          axis_d  = 1'b0;
          side_d  = 1'b0;
          state_d = ST_WMUL;
        end
      end
      ST_WMUL: state_d = ST_WCMP;
      ST_WCMP: begin
        if (hit) begin
          state_d = ST_CDIV;
          dgo_d   = 1'b1;
        end else begin
          state_d = nw_state;
          axis_d  = nw_axis;
          side_d  = nw_side;
        end
      end
      ST_CDIV: begin
        if (div_done) begin
          if (into) begin
            state_d = ST_BMUL;
          end else begin
            state_d = nw_state;
            axis_d  = nw_axis;
            side_d  = nw_side;
          end
        end
      end
      ST_BMUL: state_d = ST_BADD;
      ST_BADD: begin
        state_d = nw_state;
        axis_d  = nw_axis;
        side_d  = nw_side;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control, configuration and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      side_q      <= 1'b0;
      dgo_q       <= 1'b0;
      skip_q      <= 1'b1;
      out_valid_q <= 1'b0;
      ppm_q       <= 16'd256;
      grav_q[0]   <= 32'd0;
      grav_q[1]   <= 32'd642252;
      scr_q[0]    <= 13'd640;
      scr_q[1]    <= 13'd480;
      prev_q[0]   <= '0;
      prev_q[1]   <= '0;
      wall_q[0]   <= '0;
      wall_q[1]   <= '0;
      fdt_q       <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      side_q  <= side_d;
      dgo_q   <= dgo_d;
      skip_q  <= skip_d;
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_PPM:    ppm_q     <= cfg_data_i[15:0];
          CFG_GRAV_X: grav_q[0] <= cfg_data_i;
          CFG_GRAV_Y: grav_q[1] <= cfg_data_i;
          CFG_SCR_W:  scr_q[0]  <= cfg_data_i[12:0];
          CFG_SCR_H:  scr_q[1]  <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      if ((state_q == ST_FDIV) && div_done) begin
        wall_q[axis_q] <= div_res;
        if (axis_q) begin
          prev_q[0] <= pos_q[0][15:0];
          prev_q[1] <= pos_q[1][15:0];
          fdt_q     <= dt_q;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_q[0] <= x_value_i;
      pos_q[1] <= y_value_i;
      vel_q[0] <= vel_x_i;
      vel_q[1] <= vel_y_i;
      frc_q[0] <= force_x_i;
      frc_q[1] <= force_y_i;
      siz_q[0] <= size_x_i;
      siz_q[1] <= size_y_i;
      mass_q   <= (mass_i == 31'd0) ? 31'd1 : mass_i;
      dt_q     <= dt_i;
    end
    case (state_q)
      ST_FMUL, ST_AMUL, ST_VMUL, ST_PMUL, ST_WMUL, ST_BMUL: prod_q <= mul_a * mul_b;
      ST_ADIV: if (div_done) acc_q <= div_res;
      ST_VADD: vel_q[axis_q] <= sat_wide($signed({{36{vel_sel[31]}}, vel_sel}) + shr_tz(prod_q));
      ST_PADD: pos_q[axis_q] <= sat_wide($signed({{36{pos_sel[31]}}, pos_sel}) + shr_tz(prod_q));
      ST_CDIV: if (div_done) pos_q[axis_q] <= div_res;
      ST_BADD: vel_q[axis_q] <= sat_wide(shr_tz(prod_q) + $signed({{36{wall_sel[31]}}, wall_sel}));
      default: ;
    endcase
    // restoring divider on magnitudes, one quotient bit a cycle
    if (div_st && dgo_q) begin
      dneg_q <= div_num[63];
      quo_q  <= div_num[63] ? 64'(-div_num) : 64'(div_num);
      rem_q  <= '0;
      dden_q <= div_den;
      dcnt_q <= '0;
    end else if (div_st && !dcnt_q[6]) begin
      rem_q  <= cand_ge ? 32'(cand - {1'b0, dden_q}) : cand[31:0];
      quo_q  <= {quo_q[62:0], cand_ge};
      dcnt_q <= dcnt_q + 7'd1;
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_px_q <= pos_q[0];
      out_py_q <= pos_q[1];
      out_vx_q <= vel_q[0];
      out_vy_q <= vel_q[1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_pos_x_o = out_px_q;
  assign new_pos_y_o = out_py_q;
  assign new_vel_x_o = out_vx_q;
  assign new_vel_y_o = out_vy_q;

endmodule
`default_nettype wire

// File: rtl/pwb_checker.sv
`default_nettype none
module pwb_checker
  import pwb_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        command_i,
  input wire logic [15:0] dt_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] new_pos_x_o,
  input wire logic [31:0] new_vel_y_o
);

  // a held result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(new_pos_x_o) && $stable(new_vel_y_o))
    else $error("result changed under stall");

  // real work keeps the block busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && ((command_i == CMD_OBJECT) || (dt_i != 16'd0)) |=> in_stall_o)
    else $error("block ready right after a working request");

  // a skipped frame costs no busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (command_i == CMD_FRAME) && (dt_i == 16'd0) |=> !in_stall_o)
    else $error("zero-dt frame made the block busy");

  // new results come only out of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in flight");

endmodule

bind particle_wall_bounce_integrator pwb_checker u_pwb_checker (.*);
`default_nettype wire
